FILE: sv/psc_pkg.sv
// ----------------------------------------------------------------------------
// PID steering controller package
// Shared types, constants and the command structure.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned ERR_W       = 17;
    localparam int unsigned DIFF_W      = 18;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned DRIVE_W     = 18;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned DIV_CNT_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 3'd4;

    localparam logic [CFG_W-1:0] PROP_GAIN_RST  = 16'd2000;
    localparam logic [CFG_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [CFG_W-1:0] DERIV_GAIN_RST = 16'd0;
    localparam logic [CFG_W-1:0] WINDUP_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] DIVISOR_RST    = 16'd10;

    localparam logic [WORD_W-1:0] ROUND_BIAS = 32'd32767;
    localparam int unsigned SCALE_SHIFT = 15;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } term_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_FIX,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  acc;
        term_t term;
        logic  div_init;
        logic  div_step;
        logic  fix;
        logic  scale;
        logic  out_load;
    } cmd_t;

endpackage

`default_nettype wire

FILE: sv/psc_datapath.sv
// ----------------------------------------------------------------------------
// PID steering controller datapath
// Configuration registers, controller state, shared multiplier, serial
// divider and output scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_datapath (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        cfg_we,
    input  wire         [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire         [psc_pkg::CFG_W-1:0]           cfg_wdata,
    input  wire  signed [psc_pkg::SAMPLE_W-1:0]        s_error_sample,
    input  wire  psc_pkg::cmd_t                        cmd,
    output logic signed [psc_pkg::DRIVE_W-1:0]         m_steering_drive
);

    logic [psc_pkg::CFG_W-1:0] prop_gain_reg;
    logic [psc_pkg::CFG_W-1:0] integ_gain_reg;
    logic [psc_pkg::CFG_W-1:0] deriv_gain_reg;
    logic [psc_pkg::CFG_W-1:0] windup_reg;
    logic [psc_pkg::CFG_W-1:0] divisor_reg;

    logic [psc_pkg::WORD_W-1:0]  sum_reg;
    logic [psc_pkg::ERR_W-1:0]   prev_reg;
    logic [psc_pkg::ERR_W-1:0]   e_reg;
    logic [psc_pkg::DIFF_W-1:0]  diff_reg;
    logic                        integ_on_reg;
    logic [psc_pkg::WORD_W-1:0]  prod_reg;
    logic [psc_pkg::WORD_W-1:0]  acc_reg;
    logic [psc_pkg::WORD_W-1:0]  dvd_reg;
    logic [psc_pkg::CFG_W-1:0]   rem_reg;
    logic                        neg_reg;
    logic                        zero_div_reg;
    logic [psc_pkg::DRIVE_W-1:0] out_reg;

    logic [psc_pkg::ERR_W-1:0]   e_next;
    logic                        integ_on_next;
    logic [psc_pkg::CFG_W-1:0]   gain_sel;
    logic [psc_pkg::WORD_W-1:0]  opnd_sel;
    logic [47:0]                 mul_full;
    logic [psc_pkg::CFG_W:0]     shifted;
    logic [psc_pkg::CFG_W:0]     trial;
    logic                        q_bit;
    logic [psc_pkg::WORD_W-1:0]  q_fix;
    logic [psc_pkg::WORD_W-1:0]  scaled;
    logic [psc_pkg::WORD_W-1:0]  biased;
    logic [psc_pkg::DRIVE_W-1:0] r_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= psc_pkg::PROP_GAIN_RST;
            integ_gain_reg <= psc_pkg::INTEG_GAIN_RST;
            deriv_gain_reg <= psc_pkg::DERIV_GAIN_RST;
            windup_reg     <= psc_pkg::WINDUP_RST;
            divisor_reg    <= psc_pkg::DIVISOR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                psc_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                psc_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_wdata;
                psc_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata;
                psc_pkg::REG_WINDUP:     windup_reg     <= cfg_wdata;
                psc_pkg::REG_DIVISOR:    divisor_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign e_next = psc_pkg::ERR_W'(-$signed({s_error_sample[psc_pkg::SAMPLE_W-1],
                                              s_error_sample}));
    assign integ_on_next = sum_reg[psc_pkg::WORD_W-1]
                         || (sum_reg < {16'd0, windup_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end else if (cmd.load) begin
            prev_reg <= e_next;
            if (integ_on_next) begin
                sum_reg <= sum_reg + {{(psc_pkg::WORD_W-psc_pkg::ERR_W){e_next[psc_pkg::ERR_W-1]}},
                                      e_next};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            e_reg        <= e_next;
            integ_on_reg <= integ_on_next;
            diff_reg     <= {prev_reg[psc_pkg::ERR_W-1], prev_reg}
                          - {e_next[psc_pkg::ERR_W-1], e_next};
        end
    end

    always_comb begin
        unique case (cmd.term)
            psc_pkg::TERM_P: begin
                gain_sel = prop_gain_reg;
                opnd_sel = {{(psc_pkg::WORD_W-psc_pkg::ERR_W){e_reg[psc_pkg::ERR_W-1]}}, e_reg};
            end
            psc_pkg::TERM_I: begin
                gain_sel = integ_on_reg ? integ_gain_reg : '0;
                opnd_sel = sum_reg;
            end
            psc_pkg::TERM_D: begin
                gain_sel = deriv_gain_reg;
                opnd_sel = {{(psc_pkg::WORD_W-psc_pkg::DIFF_W){diff_reg[psc_pkg::DIFF_W-1]}},
                            diff_reg};
            end
            default: begin
                gain_sel = '0;
                opnd_sel = '0;
            end
        endcase
    end

    assign mul_full = {32'd0, gain_sel} * {16'd0, opnd_sel};

    assign shifted = {rem_reg, dvd_reg[psc_pkg::WORD_W-1]};
    assign trial   = shifted - {1'b0, divisor_reg};
    assign q_bit   = (shifted >= {1'b0, divisor_reg});
    assign q_fix   = zero_div_reg ? '0 : (neg_reg ? (~dvd_reg + 32'd1) : dvd_reg);
    assign scaled  = (acc_reg << 6) + (acc_reg << 5) + (acc_reg << 2);
    assign biased  = prod_reg + (prod_reg[psc_pkg::WORD_W-1] ? psc_pkg::ROUND_BIAS : '0);
    assign r_ext   = {biased[psc_pkg::WORD_W-1], biased[psc_pkg::WORD_W-1:psc_pkg::SCALE_SHIFT]};

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= mul_full[psc_pkg::WORD_W-1:0];
        end else if (cmd.scale) begin
            prod_reg <= scaled;
        end
        if (cmd.acc) begin
            acc_reg <= ((cmd.term == psc_pkg::TERM_P) ? '0 : acc_reg) + prod_reg;
        end else if (cmd.fix) begin
            acc_reg <= q_fix;
        end
        if (cmd.div_init) begin
            neg_reg      <= acc_reg[psc_pkg::WORD_W-1];
            zero_div_reg <= (divisor_reg == '0);
            dvd_reg      <= acc_reg[psc_pkg::WORD_W-1] ? (~acc_reg + 32'd1) : acc_reg;
            rem_reg      <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[psc_pkg::WORD_W-2:0], q_bit};
            rem_reg <= q_bit ? trial[psc_pkg::CFG_W-1:0] : shifted[psc_pkg::CFG_W-1:0];
        end
        if (cmd.out_load) begin
            out_reg <= psc_pkg::DRIVE_W'(-$signed(r_ext));
        end
    end

    assign m_steering_drive = $signed(out_reg);

endmodule

`default_nettype wire

FILE: sv/psc_ctrl.sv
// ----------------------------------------------------------------------------
// PID steering controller sequencer
// State machine that steps the datapath through load, three multiply and
// accumulate passes, the serial divide and the output scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_ctrl (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire             m_ready,
    output psc_pkg::cmd_t   cmd
);

    psc_pkg::state_t                 state_reg, state_next;
    psc_pkg::term_t                  term_reg, term_next;
    logic [psc_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psc_pkg::ST_IDLE;
            term_reg  <= psc_pkg::TERM_P;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_ready;
        cmd        = '0;
        cmd.term   = term_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            psc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = psc_pkg::ST_LOAD;
                end
            end
            psc_pkg::ST_LOAD: begin
                term_next  = psc_pkg::TERM_P;
                state_next = psc_pkg::ST_MUL;
            end
            psc_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = psc_pkg::ST_ACC;
            end
            psc_pkg::ST_ACC: begin
                cmd.acc = 1'b1;
                unique case (term_reg)
                    psc_pkg::TERM_P: begin
                        term_next  = psc_pkg::TERM_I;
                        state_next = psc_pkg::ST_MUL;
                    end
                    psc_pkg::TERM_I: begin
                        term_next  = psc_pkg::TERM_D;
                        state_next = psc_pkg::ST_MUL;
                    end
                    default: begin
                        state_next = psc_pkg::ST_DIV_INIT;
                    end
                endcase
            end
            psc_pkg::ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = psc_pkg::ST_DIV_STEP;
            end
            psc_pkg::ST_DIV_STEP: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == psc_pkg::DIV_CNT_W'(psc_pkg::DIV_STEPS - 1)) begin
                    state_next = psc_pkg::ST_FIX;
                end
            end
            psc_pkg::ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = psc_pkg::ST_SCALE;
            end
            psc_pkg::ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = psc_pkg::ST_DONE;
            end
            psc_pkg::ST_DONE: begin
                if (!valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = psc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = valid_reg;

endmodule

`default_nettype wire

FILE: sv/pid_steering_controller_core.sv
// An accepted input transaction runs through three passes of one shared
// multiplier and the 32-step restoring divider before m_valid is raised.
// Input is accepted only while the sequencer is idle; the output register holds
// a finished result while the next input transaction is accepted and processed.
// Reset: synchronous active-low aresetn restores the register defaults and
// clears the integral sum, the previous error and m_valid.
// ----------------------------------------------------------------------------
// PID steering controller core
// Discrete PID controller with integrator clamp, a serial divide by a
// configurable divisor and fixed output scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_steering_controller_core (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        cfg_we,
    input  wire         [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire         [psc_pkg::CFG_W-1:0]           cfg_wdata,
    input  wire                                        s_valid,
    output logic                                       s_ready,
    input  wire  signed [psc_pkg::SAMPLE_W-1:0]        s_error_sample,
    output logic                                       m_valid,
    input  wire                                        m_ready,
    output logic signed [psc_pkg::DRIVE_W-1:0]         m_steering_drive
);

    psc_pkg::cmd_t cmd;

    psc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    psc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_error_sample   (s_error_sample),
        .cmd              (cmd),
        .m_steering_drive (m_steering_drive)
    );

endmodule

`default_nettype wire

FILE: verif/tb_pid_steering_controller_core.sv
// ----------------------------------------------------------------------------
// PID steering controller core testbench
// Feeds steering error samples over a valid/ready channel with bursty traffic,
// stalls the drive output on a changing pattern, and compares each steering
// drive with a cycle-free behavioral predictor across several gain, windup
// and divisor settings, including the extremes and a zero divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pid_steering_controller_core;

    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_SAMPLES  = 112;

    localparam logic [psc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [psc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [psc_pkg::CFG_IDX_W-1:0]     index;
        logic [psc_pkg::CFG_W-1:0]         value;
        logic                              has_fixed;
        logic [psc_pkg::DRIVE_W-1:0]       fixed_drive;
    } stim_row_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [psc_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [psc_pkg::CFG_W-1:0]            cfg_wdata = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic signed [psc_pkg::SAMPLE_W-1:0]  s_error_sample = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [psc_pkg::DRIVE_W-1:0]   m_steering_drive;

    // Predictor copy of the registers and the loop state.
    logic [psc_pkg::CFG_W-1:0]            gain_p = psc_pkg::PROP_GAIN_RST;
    logic [psc_pkg::CFG_W-1:0]            gain_i = psc_pkg::INTEG_GAIN_RST;
    logic [psc_pkg::CFG_W-1:0]            gain_d = psc_pkg::DERIV_GAIN_RST;
    logic [psc_pkg::CFG_W-1:0]            windup_lim = psc_pkg::WINDUP_RST;
    logic [psc_pkg::CFG_W-1:0]            divisor = psc_pkg::DIVISOR_RST;
    logic [psc_pkg::WORD_W-1:0]           integ_acc = '0;
    int                                   last_err = 0;

    logic [psc_pkg::DRIVE_W-1:0]          drive_q[$];
    stim_row_t                            dir_rows[$];
    int                                   mismatch_count = 0;
    int                                   burst_left = 0;
    int                                   idle_cycles = 0;
    int                                   stall_mode = 0;
    int                                   stall_left = 0;

    pid_steering_controller_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_error_sample   (s_error_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_steering_drive (m_steering_drive)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [psc_pkg::DRIVE_W-1:0] predict_drive(
        input logic signed [psc_pkg::SAMPLE_W-1:0] smp);
        int                         err;
        logic [psc_pkg::WORD_W-1:0] err_w;
        logic [psc_pkg::WORD_W-1:0] diff_w;
        logic [psc_pkg::WORD_W-1:0] term_p;
        logic [psc_pkg::WORD_W-1:0] term_i;
        logic [psc_pkg::WORD_W-1:0] term_d;
        logic [psc_pkg::WORD_W-1:0] total;
        logic [psc_pkg::WORD_W-1:0] quo_w;
        logic [psc_pkg::WORD_W-1:0] scaled;
        longint                     quo;
        longint                     pct;
        err = -int'(smp);
        err_w = err;
        term_p = {16'b0, gain_p} * err_w;
        term_i = '0;
        if (longint'($signed(integ_acc)) < longint'(windup_lim)) begin
            integ_acc = integ_acc + err_w;
            term_i = {16'b0, gain_i} * integ_acc;
        end
        diff_w = last_err - err;
        term_d = {16'b0, gain_d} * diff_w;
        last_err = err;
        total = term_p + term_i + term_d;
        if (divisor == '0) begin
            quo = 0;
        end else begin
            quo = longint'($signed(total)) / longint'(divisor);
        end
        quo_w = quo[psc_pkg::WORD_W-1:0];
        scaled = quo_w * 32'd100;
        pct = -(longint'($signed(scaled)) / 32768);
        return pct[psc_pkg::DRIVE_W-1:0];
    endfunction

    function automatic logic [psc_pkg::CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return psc_pkg::CFG_W'($urandom_range(1, 16));
            3: return psc_pkg::CFG_W'($urandom_range(100, 3000));
            default: return psc_pkg::CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [psc_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
            3, 4, 5: return psc_pkg::SAMPLE_W'($urandom);
            default: return psc_pkg::SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [psc_pkg::CFG_IDX_W-1:0] index,
                           input logic [psc_pkg::CFG_W-1:0] value, input logic has_fixed,
                           input logic [psc_pkg::DRIVE_W-1:0] fixed_drive);
        dir_rows.push_back({kind, index, value, has_fixed, fixed_drive});
    endtask

    task automatic write_reg(input logic [psc_pkg::CFG_IDX_W-1:0] index,
                             input logic [psc_pkg::CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (index)
            psc_pkg::REG_PROP_GAIN: gain_p = value;
            psc_pkg::REG_INTEG_GAIN: gain_i = value;
            psc_pkg::REG_DERIV_GAIN: gain_d = value;
            psc_pkg::REG_WINDUP: windup_lim = value;
            psc_pkg::REG_DIVISOR: divisor = value;
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [psc_pkg::SAMPLE_W-1:0] smp, input logic has_fixed,
                               input logic [psc_pkg::DRIVE_W-1:0] fixed_drive);
        logic [psc_pkg::DRIVE_W-1:0] want;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 60)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 6);
        end
        s_valid <= 1'b1;
        s_error_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = predict_drive(smp);
        drive_q.push_back(has_fixed ? fixed_drive : want);
        burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        if (burst_left != 0) begin
            s_valid <= 1'b0;
            burst_left = 0;
        end
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 400);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected steering_drive transaction, expected none, got %0d",
                             $time, m_steering_drive);
                    mismatch_count++;
                end else begin
                    if (m_steering_drive !== $signed(drive_q[0])) begin
                        $display("%0t: steering_drive expected %0d, got %0d",
                                 $time, $signed(drive_q[0]), m_steering_drive);
                        mismatch_count++;
                    end
                    void'(drive_q.pop_front());
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic quiet;
        quiet = 1'b0;

        // Reset defaults first, then the extremes of the gains and the sample.
        add_row(ROW_SAMPLE, '0, 16'h0000, 1'b1, 18'd0);
        add_row(ROW_SAMPLE, '0, 16'd1234, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'hFB2E, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_PROP_GAIN, 16'hFFFF, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_INTEG_GAIN, 16'h0000, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_DERIV_GAIN, 16'h0000, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_DIVISOR, 16'd1, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h8000, 1'b1, 18'd100);
        add_row(ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_INTEG_GAIN, 16'hFFFF, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_DERIV_GAIN, 16'hFFFF, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_WINDUP, 16'hFFFF, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h8000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h8000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h0000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h0001, 1'b0, '0);
        // A zero windup limit freezes the positive integral sum.
        add_row(ROW_WRITE, psc_pkg::REG_WINDUP, 16'h0000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'hFFFB, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h0005, 1'b0, '0);
        // A zero divisor forces a zero drive.
        add_row(ROW_WRITE, psc_pkg::REG_DIVISOR, 16'h0000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h7FFF, 1'b1, 18'd0);
        add_row(ROW_SAMPLE, '0, 16'h8000, 1'b1, 18'd0);
        // Writes to unused register indexes must leave the divisor at zero.
        add_row(ROW_WRITE, REG_SPARE_LO, 16'hFFFF, 1'b0, '0);
        add_row(ROW_WRITE, REG_SPARE_HI, 16'h0001, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'd77, 1'b1, 18'd0);
        add_row(ROW_WRITE, psc_pkg::REG_DIVISOR, 16'hFFFF, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_WINDUP, 16'd1000, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_PROP_GAIN, 16'd2000, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_INTEG_GAIN, 16'd7, 1'b0, '0);
        add_row(ROW_WRITE, psc_pkg::REG_DERIV_GAIN, 16'd300, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h4000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'hC000, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'h5555, 1'b0, '0);
        add_row(ROW_SAMPLE, '0, 16'hAAAA, 1'b0, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                if (!quiet) begin
                    drain_results();
                    quiet = 1'b1;
                end
                write_reg(dir_rows[i].index, dir_rows[i].value);
            end else begin
                send_sample(dir_rows[i].value, dir_rows[i].has_fixed, dir_rows[i].fixed_drive);
                quiet = 1'b0;
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            write_reg(psc_pkg::REG_PROP_GAIN, pick_setting());
            write_reg(psc_pkg::REG_INTEG_GAIN, pick_setting());
            write_reg(psc_pkg::REG_DERIV_GAIN, pick_setting());
            write_reg(psc_pkg::REG_WINDUP, pick_setting());
            write_reg(psc_pkg::REG_DIVISOR, ($urandom_range(0, 7) == 0) ? 16'h0000
                                            : (pick_setting() | 16'h0001));
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                send_sample(pick_sample(), 1'b0, '0);
                if ($urandom_range(0, 99) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/psc_pkg.sv
sv/psc_datapath.sv
sv/psc_ctrl.sv
sv/pid_steering_controller_core.sv
verif/tb_pid_steering_controller_core.sv
